// ===== hdl/tor_pkg.sv =====
// Shared types and codes for the triangle occupancy raster unit.
// No dependencies.
package tor_pkg;

  localparam int CW = 8;   // box and bitmap coordinate width
  localparam int EW = 20;  // edge function accumulator width

  typedef logic [CW-1:0]        coord_t;
  typedef logic signed [CW:0]   coef_t;
  typedef logic signed [2*CW+1:0] prod_t;
  typedef logic signed [EW-1:0] edge_t;

  localparam logic [1:0] REQ_TEST  = 2'd0;
  localparam logic [1:0] REQ_DRAW  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
  localparam logic [1:0] STATUS_OVERLAP = 2'd2;

  localparam logic MARK_OCCUPIED = 1'b1;

  typedef enum logic [2:0] {
    K_TEST = 3'd0,
    K_DRAW = 3'd1,
    K_CLR  = 3'd2,
    K_NOP  = 3'd3,
    K_OUT  = 3'd4
  } cmd_kind_t;

  // Classified request handed from front to back.
  typedef struct packed {
    cmd_kind_t kind;
    coord_t    lox;
    coord_t    hix;
    coord_t    loy;
    coord_t    hiy;
    logic      neg;
    edge_t     e1;
    edge_t     e2;
    edge_t     e3;
    coef_t     p1;
    coef_t     q1;
    coef_t     p2;
    coef_t     q2;
    coef_t     p3;
    coef_t     q3;
  } cmd_t;

  function automatic coef_t sdiff(input coord_t a, input coord_t b);
    sdiff = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

endpackage

// ===== hdl/tor_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on nothing.
interface tor_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [10:0] vertex1_x;
  logic signed [10:0] vertex1_y;
  logic signed [10:0] vertex2_x;
  logic signed [10:0] vertex2_y;
  logic signed [10:0] vertex3_x;
  logic signed [10:0] vertex3_y;
  logic [7:0]         box_xmin;
  logic [7:0]         box_xmax;
  logic [7:0]         box_bottom;
  logic [7:0]         box_top;

  modport source(output valid, req_type, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
                 vertex3_x, vertex3_y, box_xmin, box_xmax, box_bottom, box_top,
                 input ready);
  modport sink(input valid, req_type, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
               vertex3_x, vertex3_y, box_xmin, box_xmax, box_bottom, box_top,
               output ready);
endinterface

interface tor_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;

  modport source(output valid, status, input ready);
  modport sink(input valid, status, output ready);
endinterface

// ===== hdl/tor_front.sv =====
// Front end: accepts requests, checks the bounding box, sets up edge functions.
// Depends on tor_pkg and tor_in_if.
module tor_front (
  input  logic          clk,
  input  logic          rst_n,
  tor_in_if.sink        in_if,
  input  logic          back_ready,
  input  logic          q_full,
  output logic          q_push,
  output tor_pkg::cmd_t q_data
);
  import tor_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fst_t;

  fst_t      st_r, st_nxt;
  logic [1:0] step_r;
  cmd_kind_t kind_r;
  coord_t    ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  coord_t    lox_r, hix_r, loy_r, hiy_r;
  edge_t     e1_r, e2_r, e3_r;
  logic      neg_r;

  logic signed [10:0] lox, hix, loy, hiy;
  logic      fits, acc;
  coef_t     ma, mb, mc, md;
  prod_t     pa, pb;
  edge_t     mres;

  function automatic logic signed [10:0] min3(input logic signed [10:0] a,
                                              input logic signed [10:0] b,
                                              input logic signed [10:0] c);
    logic signed [10:0] m;
    m = (a < b) ? a : b;
    min3 = (m < c) ? m : c;
  endfunction

  function automatic logic signed [10:0] max3(input logic signed [10:0] a,
                                              input logic signed [10:0] b,
                                              input logic signed [10:0] c);
    logic signed [10:0] m;
    m = (a > b) ? a : b;
    max3 = (m > c) ? m : c;
  endfunction

  assign in_if.ready = (st_r == F_IDLE) && back_ready;
  assign acc = in_if.valid && in_if.ready;

  always_comb begin
    lox  = min3(in_if.vertex1_x, in_if.vertex2_x, in_if.vertex3_x);
    hix  = max3(in_if.vertex1_x, in_if.vertex2_x, in_if.vertex3_x);
    loy  = min3(in_if.vertex1_y, in_if.vertex2_y, in_if.vertex3_y);
    hiy  = max3(in_if.vertex1_y, in_if.vertex2_y, in_if.vertex3_y);
    fits = (lox >= $signed({3'b000, in_if.box_xmin}))  &&
           (hix <= $signed({3'b000, in_if.box_xmax})) &&
           (loy >= $signed({3'b000, in_if.box_bottom})) &&
           (hiy <= $signed({3'b000, in_if.box_top}));
  end

  // one a*b - c*d per cycle
  always_comb begin
    case (step_r)
      2'd0: begin
        ma = sdiff(bx_r, ax_r); mb = sdiff(loy_r, ay_r);
        mc = sdiff(by_r, ay_r); md = sdiff(lox_r, ax_r);
      end
      2'd1: begin
        ma = sdiff(cx_r, bx_r); mb = sdiff(loy_r, by_r);
        mc = sdiff(cy_r, by_r); md = sdiff(lox_r, bx_r);
      end
      2'd2: begin
        ma = sdiff(ax_r, cx_r); mb = sdiff(loy_r, cy_r);
        mc = sdiff(ay_r, cy_r); md = sdiff(lox_r, cx_r);
      end
      default: begin
        ma = sdiff(bx_r, ax_r); mb = sdiff(cy_r, ay_r);
        mc = sdiff(cx_r, ax_r); md = sdiff(by_r, ay_r);
      end
    endcase
    pa   = ma * mb;
    pb   = mc * md;
    mres = edge_t'(pa) - edge_t'(pb);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE: if (acc) begin
        st_nxt = ((in_if.req_type == REQ_TEST || in_if.req_type == REQ_DRAW) && fits)
                 ? F_MUL : F_PUSH;
      end
      F_MUL:  if (step_r == 2'd3) st_nxt = F_PUSH;
      F_PUSH: if (!q_full) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      step_r <= 2'd0;
    end else begin
      st_r <= st_nxt;
      if (st_r == F_MUL) step_r <= step_r + 2'd1;
      else               step_r <= 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      case (in_if.req_type)
        REQ_TEST:  kind_r <= fits ? K_TEST : K_OUT;
        REQ_DRAW:  kind_r <= fits ? K_DRAW : K_OUT;
        REQ_CLEAR: kind_r <= K_CLR;
        default:   kind_r <= K_NOP;
      endcase
      ax_r  <= coord_t'(in_if.vertex1_x[7:0]);
      ay_r  <= coord_t'(in_if.vertex1_y[7:0]);
      bx_r  <= coord_t'(in_if.vertex2_x[7:0]);
      by_r  <= coord_t'(in_if.vertex2_y[7:0]);
      cx_r  <= coord_t'(in_if.vertex3_x[7:0]);
      cy_r  <= coord_t'(in_if.vertex3_y[7:0]);
      lox_r <= coord_t'(lox[7:0]);
      hix_r <= coord_t'(hix[7:0]);
      loy_r <= coord_t'(loy[7:0]);
      hiy_r <= coord_t'(hiy[7:0]);
    end
    if (st_r == F_MUL) begin
      case (step_r)
        2'd0:    e1_r  <= mres;
        2'd1:    e2_r  <= mres;
        2'd2:    e3_r  <= mres;
        default: neg_r <= mres < 0;
      endcase
    end
  end

  assign q_push = (st_r == F_PUSH) && !q_full;

  always_comb begin
    q_data      = '0;
    q_data.kind = kind_r;
    q_data.lox  = lox_r;
    q_data.hix  = hix_r;
    q_data.loy  = loy_r;
    q_data.hiy  = hiy_r;
    q_data.neg  = neg_r;
    q_data.e1   = e1_r;
    q_data.e2   = e2_r;
    q_data.e3   = e3_r;
    q_data.p1   = sdiff(bx_r, ax_r);
    q_data.q1   = sdiff(by_r, ay_r);
    q_data.p2   = sdiff(cx_r, bx_r);
    q_data.q2   = sdiff(cy_r, by_r);
    q_data.p3   = sdiff(ax_r, cx_r);
    q_data.q3   = sdiff(ay_r, cy_r);
  end

endmodule

// ===== hdl/tor_queue.sv =====
// Two-entry command queue between front and back.
// Depends on tor_pkg.
module tor_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tor_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output tor_pkg::cmd_t rdata
);
  import tor_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= wdata;
  end

endmodule

// ===== hdl/tor_back.sv =====
// Back end: bitmap row memory, pixel walk, row test/mark, clear sweep, result register.
// Depends on tor_pkg and tor_out_if.
module tor_back #(
  parameter int GRID_DIM = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  tor_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          ready,
  tor_out_if.source     out_if
);
  import tor_pkg::*;

  localparam int RW = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam int MW = GRID_DIM + 1;  // one extra column for a pixel just off the right edge

  typedef enum logic [6:0] {
    B_INIT = 7'b0000001,
    B_IDLE = 7'b0000010,
    B_CLR  = 7'b0000100,
    B_WALK = 7'b0001000,
    B_RD   = 7'b0010000,
    B_OP   = 7'b0100000,
    B_DONE = 7'b1000000
  } bst_t;

  logic [GRID_DIM-1:0] mem [GRID_DIM];

  bst_t    st_r, st_nxt;
  cmd_t    cmd_r;
  logic [RW-1:0] clr_r, wa_r;
  coord_t  x_r, y_r;
  edge_t   e_r [3];
  edge_t   erow_r [3];
  logic [MW-1:0] mask_r, mask_nxt;
  logic    hit_r;
  logic [1:0] dy_r;
  logic [GRID_DIM-1:0] rd_r;
  logic    out_valid_r;
  logic [1:0] status_r;

  logic    pix_in, row_last, emit;
  logic signed [11:0] t;
  logic    t_ok;
  logic [MW-1:0] dil;
  logic [GRID_DIM-1:0] row_m;
  logic    mem_we;
  logic [RW-1:0] mem_wa;
  logic [GRID_DIM-1:0] mem_wd;

  assign ready = (st_r != B_INIT);
  assign q_pop = (st_r == B_IDLE) && !q_empty;
  assign emit  = (st_r == B_DONE) && (!out_valid_r || out_if.ready);

  always_comb begin
    pix_in = cmd_r.neg ? (e_r[0] <= 0 && e_r[1] <= 0 && e_r[2] <= 0)
                       : (e_r[0] >= 0 && e_r[1] >= 0 && e_r[2] >= 0);
    mask_nxt = mask_r | (pix_in ? ({{(MW-1){1'b0}}, 1'b1} << x_r) : '0);
    row_last = (y_r == cmd_r.hiy);
    t    = $signed({4'b0000, y_r}) + $signed({10'b0, dy_r}) - 12'sd1;
    t_ok = !t[11] && (t < $signed(12'(GRID_DIM)));
    dil  = mask_r | (mask_r << 1) | (mask_r >> 1);
    row_m = (dy_r == 2'd1) ? dil[GRID_DIM-1:0] : mask_r[GRID_DIM-1:0];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_INIT: if (clr_r == RW'(GRID_DIM - 1)) st_nxt = B_IDLE;
      B_IDLE: if (!q_empty) begin
        case (q_data.kind)
          K_CLR:   st_nxt = B_CLR;
          K_TEST:  st_nxt = B_WALK;
          K_DRAW:  st_nxt = B_WALK;
          default: st_nxt = B_DONE;
        endcase
      end
      B_CLR:  if (clr_r == RW'(GRID_DIM - 1)) st_nxt = B_DONE;
      B_WALK: if (x_r == cmd_r.hix) begin
        if (mask_nxt != '0) st_nxt = B_RD;
        else if (row_last)  st_nxt = B_DONE;
      end
      B_RD: begin
        if (t_ok)                st_nxt = B_OP;
        else if (dy_r == 2'd2)   st_nxt = row_last ? B_DONE : B_WALK;
      end
      B_OP: begin
        if (dy_r == 2'd2) st_nxt = row_last ? B_DONE : B_WALK;
        else              st_nxt = B_RD;
      end
      B_DONE: if (emit) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_INIT;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == B_INIT || st_r == B_CLR) begin
        clr_r <= (clr_r == RW'(GRID_DIM - 1)) ? '0 : clr_r + 1'b1;
      end
      if (emit)              out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  // advance to the next bounding-box row
  task automatic next_row();
    y_r    <= y_r + 1'b1;
    x_r    <= cmd_r.lox;
    mask_r <= '0;
    e_r[0] <= erow_r[0] + edge_t'(cmd_r.p1);
    e_r[1] <= erow_r[1] + edge_t'(cmd_r.p2);
    e_r[2] <= erow_r[2] + edge_t'(cmd_r.p3);
    erow_r[0] <= erow_r[0] + edge_t'(cmd_r.p1);
    erow_r[1] <= erow_r[1] + edge_t'(cmd_r.p2);
    erow_r[2] <= erow_r[2] + edge_t'(cmd_r.p3);
  endtask

  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: if (!q_empty) begin
        cmd_r  <= q_data;
        x_r    <= q_data.lox;
        y_r    <= q_data.loy;
        e_r[0] <= q_data.e1;  erow_r[0] <= q_data.e1;
        e_r[1] <= q_data.e2;  erow_r[1] <= q_data.e2;
        e_r[2] <= q_data.e3;  erow_r[2] <= q_data.e3;
        mask_r <= '0;
        hit_r  <= 1'b0;
      end
      B_WALK: begin
        if (x_r == cmd_r.hix) begin
          dy_r <= 2'd0;
          if (mask_nxt != '0) mask_r <= mask_nxt;
          else if (!row_last) next_row();
        end else begin
          mask_r <= mask_nxt;
          x_r    <= x_r + 1'b1;
          e_r[0] <= e_r[0] - edge_t'(cmd_r.q1);
          e_r[1] <= e_r[1] - edge_t'(cmd_r.q2);
          e_r[2] <= e_r[2] - edge_t'(cmd_r.q3);
        end
      end
      B_RD: begin
        wa_r <= t[RW-1:0];
        if (!t_ok) begin
          dy_r <= dy_r + 2'd1;
          if (dy_r == 2'd2 && !row_last) next_row();
        end
      end
      B_OP: begin
        if (cmd_r.kind == K_TEST && (rd_r & row_m) != '0) hit_r <= 1'b1;
        dy_r <= dy_r + 2'd1;
        if (dy_r == 2'd2 && !row_last) next_row();
      end
      default: ;
    endcase
    if (emit) begin
      case (cmd_r.kind)
        K_OUT:   status_r <= STATUS_OUTSIDE;
        K_TEST:  status_r <= hit_r ? STATUS_OVERLAP : STATUS_OK;
        default: status_r <= STATUS_OK;
      endcase
    end
  end

  // single write port: clear sweep or row mark
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wa_r;
    mem_wd = rd_r | (row_m & {GRID_DIM{MARK_OCCUPIED}});
    if (st_r == B_INIT || st_r == B_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = '0;
    end else if (st_r == B_OP && cmd_r.kind == K_DRAW) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (st_r == B_RD) rd_r <= mem[t[RW-1:0]];
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.status = status_r;

endmodule

// ===== hdl/triangle_occupancy_raster_unit.sv =====
// Top level of the triangle occupancy raster unit.
// Depends on tor_pkg, tor_if, tor_front, tor_queue, tor_back.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------------
//  in_if    | in  | valid/ready   | req_type, vertex1..3 x/y, box_xmin/xmax/bottom/top
//  out_if   | out | valid/ready   | status
//
// Flow: the front takes a request, then for a fitting test/draw runs the
// setup steps (one a*b-c*d each on a shared multiplier pair), then a push
// state, held while the queue is full. The back pops a request, walks one
// pixel a cycle over the bounding box, and for each row with inside pixels
// reads and then updates each on-grid target row (below, same, above) and
// skips the update for an off-grid one; it then emits the status word, held
// while out_if stalls. Outside and unused requests go straight to the status.
// Reset and the clear request sweep the row memory, one row a cycle; after
// reset no request is taken until that sweep ends.
// A two-entry queue lets the front set up the next request while the back
// works; the result register holds a status while the next request proceeds.
module triangle_occupancy_raster_unit #(
  parameter int GRID_DIM = 256
) (
  input logic        clk,
  input logic        rst_n,
  tor_in_if.sink     in_if,
  tor_out_if.source  out_if
);
  import tor_pkg::*;

  logic q_push, q_pop, q_full, q_empty, back_ready;
  cmd_t q_wdata, q_rdata;

  // front: classify the request and set up edge functions at the box corner
  tor_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .back_ready (back_ready),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  tor_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // back: rasterize, test or mark rows, clear sweeps, status word out
  tor_back #(
    .GRID_DIM (GRID_DIM)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .ready   (back_ready),
    .out_if  (out_if)
  );

endmodule
